@@ hdl/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the TIMEA sentence capture block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // frame buffer size, 8 to 128
  localparam int FRAME_BYTES = 128;
  localparam int COUNT_W     = 8;
  localparam int INDEX_W     = 7;

  localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(FRAME_BYTES);

  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               store_valid;
    logic [INDEX_W-1:0] store_index;
    logic [7:0]         store_byte;
    logic               frame_done;
    logic [COUNT_W-1:0] frame_length;
    logic               frame_dropped;
    logic               in_body;
  } result_t;

endpackage

@@ hdl/timea_sentence_capture.sv @@
// ----------------------------------------------------------------------------
// timea_sentence_capture
// Finds TIMEA sentences in a receiver byte stream and emits the frame bytes.
//
// Input channel in_valid/in_stall carries command and rx_byte; a command of
// release clears the frame, otherwise rx_byte is a received character.
// Output channel out_valid/out_stall carries one result beat per input beat:
// the stored byte and its index, frame done with its length, a drop flag or
// none of these, and in_body showing whether a body is being captured.
// An input beat passes through the input register and then the result
// register. One beat is taken every cycle while the receiver keeps out_stall
// low; the frame state is updated as each beat is taken.
// Reset (synchronous, active high) empties both registers and clears the
// frame state. When the receiver stalls, the result beat holds, the input
// register keeps its beat, and in_stall rises once both are full.
// ----------------------------------------------------------------------------
module timea_sentence_capture import tsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                store_valid,
  output logic [INDEX_W-1:0]  store_index,
  output logic [7:0]          store_byte,
  output logic                frame_done,
  output logic [COUNT_W-1:0]  frame_length,
  output logic                frame_dropped,
  output logic                in_body
);

  item_t   in_item, item;
  logic    item_valid, can_load, fire;
  result_t res, out_res;

  assign in_item.command = cmd_t'(command);
  assign in_item.rx_byte = rx_byte;
  assign fire            = item_valid && can_load;

  tsc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (fire)
  );

  tsc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  tsc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (item_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign store_valid   = out_res.store_valid;
  assign store_index   = out_res.store_index;
  assign store_byte    = out_res.store_byte;
  assign frame_done    = out_res.frame_done;
  assign frame_length  = out_res.frame_length;
  assign frame_dropped = out_res.frame_dropped;
  assign in_body       = out_res.in_body;

endmodule

@@ hdl/tsc_in_reg.sv @@
// ----------------------------------------------------------------------------
// tsc_in_reg
// Input register: holds one beat until the decision stage takes it.
// ----------------------------------------------------------------------------
module tsc_in_reg import tsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  advance
);

  logic load;

  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

@@ hdl/tsc_core.sv @@
// ----------------------------------------------------------------------------
// tsc_core
// Header match, body capture and terminator check; owns the frame state.
// ----------------------------------------------------------------------------
module tsc_core import tsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [COUNT_W-1:0] stored_count, stored_count_next;
  logic               header_found, header_found_next;
  logic               cr_seen, cr_seen_next;
  logic               frame_complete, frame_complete_next;
  logic [7:0]         b;
  logic               hdr_ok;

  assign b = item.rx_byte;

  // each header letter only counts at its own position
  assign hdr_ok = (b == CH_I && stored_count == COUNT_W'(1)) ||
                  (b == CH_M && stored_count == COUNT_W'(2)) ||
                  (b == CH_E && stored_count == COUNT_W'(3)) ||
                  (b == CH_A && stored_count == COUNT_W'(4));

  always_comb begin
    stored_count_next   = stored_count;
    header_found_next   = header_found;
    cr_seen_next        = cr_seen;
    frame_complete_next = frame_complete;
    res                 = '0;

    if (item.command == CMD_RELEASE) begin
      stored_count_next   = '0;
      header_found_next   = 1'b0;
      cr_seen_next        = 1'b0;
      frame_complete_next = 1'b0;
    end else if (header_found) begin
      if (cr_seen) begin
        if (b == CH_LF) begin
          frame_complete_next = 1'b1;
          header_found_next   = 1'b0;
          cr_seen_next        = 1'b0;
          res.frame_done      = 1'b1;
          res.frame_length    = stored_count;
        end else begin
          stored_count_next   = '0;
          header_found_next   = 1'b0;
          cr_seen_next        = 1'b0;
          frame_complete_next = 1'b0;
          res.frame_dropped   = 1'b1;
        end
      end else if (b == CH_CR) begin
        cr_seen_next = 1'b1;
      end else if (stored_count >= FRAME_LIMIT) begin
        // buffer full: drop the whole frame
        stored_count_next   = '0;
        header_found_next   = 1'b0;
        cr_seen_next        = 1'b0;
        frame_complete_next = 1'b0;
        res.frame_dropped   = 1'b1;
      end else begin
        res.store_valid   = 1'b1;
        res.store_index   = stored_count[INDEX_W-1:0];
        res.store_byte    = b;
        stored_count_next = stored_count + COUNT_W'(1);
      end
    end else if (b == CH_T) begin
      res.store_valid   = 1'b1;
      res.store_byte    = b;
      stored_count_next = COUNT_W'(1);
    end else if (hdr_ok) begin
      res.store_valid   = 1'b1;
      res.store_index   = stored_count[INDEX_W-1:0];
      res.store_byte    = b;
      stored_count_next = stored_count + COUNT_W'(1);
      if (b == CH_A) begin
        frame_complete_next = 1'b0;
        header_found_next   = 1'b1;
      end
    end

    res.in_body = header_found_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count   <= '0;
      header_found   <= 1'b0;
      cr_seen        <= 1'b0;
      frame_complete <= 1'b0;
    end else if (fire) begin
      stored_count   <= stored_count_next;
      header_found   <= header_found_next;
      cr_seen        <= cr_seen_next;
      frame_complete <= frame_complete_next;
    end
  end

  a_cr_in_body: assert property (@(posedge clk) disable iff (rst)
    cr_seen |-> header_found)
    else $error("cr flag set outside a body");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    stored_count <= FRAME_LIMIT)
    else $error("stored count past frame size");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_done |=> !header_found && !cr_seen && frame_complete)
    else $error("completion did not close the frame");

  a_complete_idle: assert property (@(posedge clk) disable iff (rst)
    frame_complete |-> !header_found)
    else $error("finished frame flag set while capturing a body");

endmodule

@@ hdl/tsc_out_reg.sv @@
// ----------------------------------------------------------------------------
// tsc_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module tsc_out_reg import tsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_res <= res;
    end
  end

endmodule
